// ===== rtl/txbd_pkg.sv =====
package txbd_pkg;

  // Palettes and per-texel selector fields
  typedef logic [3:0][7:0]  cpal_t;
  typedef logic [7:0][7:0]  apal_t;
  typedef logic [15:0][1:0] csel_t;
  typedef logic [15:0][2:0] asel_t;

  // Control from the top level into the texel merge stage
  typedef struct packed {
    logic load;
    logic alpha_mode;
  } emit_ctl_t;

  // Status from the texel merge stage back to the top level
  typedef struct packed {
    logic active;
    logic at_last;
  } emit_stat_t;

  localparam logic [3:0]  LastTexel   = 4'd15;
  localparam logic [7:0]  AlphaOpaque = 8'hff;
  localparam int unsigned ModeBit     = 15;

  // x/7 and x/5 as (x * recip) >> 14, exact for the sums that occur here
  localparam logic [11:0] Recip7     = 12'd2341;
  localparam logic [11:0] Recip5     = 12'd3277;
  localparam int unsigned RecipShift = 14;

endpackage

// ===== rtl/txbd_color_lane.sv =====
module txbd_color_lane #(
  parameter int unsigned BW = 5
) (
  input  logic                 clk,
  input  logic                 en,
  input  logic                 mode,
  input  logic [4:0]           a_raw,
  input  logic [BW-1:0]        b_raw,
  output txbd_pkg::cpal_t      pal
);

  logic [7:0]  a8;
  logic [7:0]  b8;
  logic [5:0]  q;
  logic [10:0] mix_a;
  logic [10:0] mix_b;
  txbd_pkg::cpal_t pal_next;

  assign a8 = {a_raw, a_raw[4:2]};
  assign b8 = {b_raw, b_raw[BW-1 -: 8-BW]};
  assign q  = b8[7:2];

  assign mix_a = 11'(a8) * 11'd5 + 11'(b8) * 11'd3;
  assign mix_b = 11'(a8) * 11'd3 + 11'(b8) * 11'd5;

  always_comb begin
    pal_next[3] = b8;
    if (mode) begin
      pal_next[0] = 8'd0;
      pal_next[1] = (a8 > 8'(q)) ? (a8 - 8'(q)) : 8'd0;
      pal_next[2] = a8;
    end else begin
      pal_next[0] = a8;
      pal_next[1] = mix_a[10:3];
      pal_next[2] = mix_b[10:3];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      pal <= pal_next;
    end
  end

endmodule

// ===== rtl/txbd_alpha_lane.sv =====
module txbd_alpha_lane (
  input  logic            clk,
  input  logic            load,
  input  logic            advance,
  input  logic [7:0]      a0,
  input  logic [7:0]      a1,
  output txbd_pkg::apal_t pal
);

  logic              gt;
  logic [7:0]        a0_r;
  logic [7:0]        a1_r;
  logic [5:0][10:0]  sum;
  logic [5:0][10:0]  sum_next;
  txbd_pkg::apal_t   pal_next;

  // Weighted sums: six if a0 > a1, else four
  always_comb begin
    for (int j = 0; j < 6; j++) begin
      if (a0 > a1) begin
        sum_next[j] = 11'(a0) * 11'(6 - j) + 11'(a1) * 11'(j + 1);
      end else if (j < 4) begin
        sum_next[j] = 11'(a0) * 11'(4 - j) + 11'(a1) * 11'(j + 1);
      end else begin
        sum_next[j] = 11'd0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      gt   <= (a0 > a1);
      a0_r <= a0;
      a1_r <= a1;
      sum  <= sum_next;
    end
  end

  // Divide by 7 or 5 through a reciprocal multiply
  always_comb begin
    logic [22:0] prod;
    pal_next[0] = a0_r;
    pal_next[1] = a1_r;
    for (int j = 0; j < 6; j++) begin
      prod = 23'(sum[j]) * 23'(gt ? txbd_pkg::Recip7 : txbd_pkg::Recip5);
      if (gt || j < 4) begin
        pal_next[j+2] = prod[txbd_pkg::RecipShift +: 8];
      end else if (j == 4) begin
        pal_next[j+2] = 8'd0;
      end else begin
        pal_next[j+2] = txbd_pkg::AlphaOpaque;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      pal <= pal_next;
    end
  end

endmodule

// ===== rtl/txbd_texel_merge.sv =====
module txbd_texel_merge (
  input  logic                  clk,
  input  logic                  rst,
  input  txbd_pkg::emit_ctl_t   ctl,
  output txbd_pkg::emit_stat_t  stat,
  input  txbd_pkg::cpal_t       pal_low_in,
  input  txbd_pkg::cpal_t       pal_mid_in,
  input  txbd_pkg::cpal_t       pal_high_in,
  input  txbd_pkg::apal_t       apal_in,
  input  txbd_pkg::csel_t       csel_in,
  input  txbd_pkg::asel_t       asel_in,
  output logic                  texel_valid,
  output logic [3:0]            texel_number,
  output logic [7:0]            part_low,
  output logic [7:0]            part_mid,
  output logic [7:0]            part_high,
  output logic [7:0]            alpha_out,
  output logic                  last_texel
);

  logic            active;
  logic [3:0]      cnt;
  txbd_pkg::cpal_t pal_low;
  txbd_pkg::cpal_t pal_mid;
  txbd_pkg::cpal_t pal_high;
  txbd_pkg::apal_t apal;
  txbd_pkg::csel_t csel;
  txbd_pkg::asel_t asel;
  logic [1:0]      ci;
  logic [2:0]      ai;

  assign ci = csel[cnt];
  assign ai = asel[cnt];

  assign stat.active  = active;
  assign stat.at_last = (cnt == txbd_pkg::LastTexel);

  always_ff @(posedge clk) begin
    if (rst) begin
      active      <= 1'b0;
      cnt         <= 4'd0;
      texel_valid <= 1'b0;
    end else begin
      texel_valid <= active;
      if (ctl.load) begin
        active <= 1'b1;
        cnt    <= 4'd0;
      end else if (active) begin
        cnt <= cnt + 4'd1;
        if (cnt == txbd_pkg::LastTexel) begin
          active <= 1'b0;
        end
      end
    end
  end

  // Hold the block being streamed; a new one loads as the last texel leaves
  always_ff @(posedge clk) begin
    if (ctl.load) begin
      pal_low  <= pal_low_in;
      pal_mid  <= pal_mid_in;
      pal_high <= pal_high_in;
      apal     <= apal_in;
      csel     <= csel_in;
      asel     <= asel_in;
    end
    texel_number <= cnt;
    last_texel   <= (cnt == txbd_pkg::LastTexel);
    part_low     <= pal_low[ci];
    part_mid     <= pal_mid[ci];
    part_high    <= pal_high[ci];
    alpha_out    <= ctl.alpha_mode ? apal[ai] : txbd_pkg::AlphaOpaque;
  end

endmodule

// ===== rtl/atc_texture_block_decoder.sv =====
// From an accepted start to the first texel beat, with the pipeline empty, a
// block passes the input register, palette stage, load and output register.
// Throughput: one texel beat per cycle while a block streams, set by the texel
// merge stage; a waiting block loads as the last texel before it leaves.
// busy rises only while two blocks wait behind the one being streamed.
// Reset clears all valid state and alpha_mode; the receiver cannot stall.
module atc_texture_block_decoder (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  logic        cfg_data,
  input  logic        start,
  output logic        busy,
  input  logic [15:0] color_endpoint0,
  input  logic [15:0] color_endpoint1,
  input  logic [31:0] color_selectors,
  input  logic [7:0]  alpha_endpoint0,
  input  logic [7:0]  alpha_endpoint1,
  input  logic [47:0] alpha_selectors,
  output logic        texel_valid,
  output logic [3:0]  texel_number,
  output logic [7:0]  part_low,
  output logic [7:0]  part_mid,
  output logic [7:0]  part_high,
  output logic [7:0]  alpha_out,
  output logic        last_texel
);

  logic                 alpha_mode;
  logic                 s1_valid;
  logic                 s2_valid;
  logic                 accept;
  logic                 s1_move;
  logic                 s2_move;
  logic                 emit_free;
  logic [15:0]          e0;
  logic [15:0]          e1;
  txbd_pkg::csel_t      csel1;
  txbd_pkg::asel_t      asel1;
  txbd_pkg::csel_t      csel2;
  txbd_pkg::asel_t      asel2;
  txbd_pkg::cpal_t      pal_low;
  txbd_pkg::cpal_t      pal_mid;
  txbd_pkg::cpal_t      pal_high;
  txbd_pkg::apal_t      apal;
  txbd_pkg::emit_ctl_t  ctl;
  txbd_pkg::emit_stat_t stat;

  assign emit_free = !stat.active || stat.at_last;
  assign s2_move   = s2_valid && emit_free;
  assign s1_move   = s1_valid && (!s2_valid || s2_move);
  assign busy      = s1_valid && !(!s2_valid || s2_move);
  assign accept    = start && !busy;

  assign ctl.load       = s2_move;
  assign ctl.alpha_mode = alpha_mode;

  always_ff @(posedge clk) begin
    if (rst) begin
      alpha_mode <= 1'b0;
      s1_valid   <= 1'b0;
      s2_valid   <= 1'b0;
    end else begin
      if (cfg_we) begin
        alpha_mode <= cfg_data;
      end
      if (accept) begin
        s1_valid <= 1'b1;
      end else if (s1_move) begin
        s1_valid <= 1'b0;
      end
      if (s1_move) begin
        s2_valid <= 1'b1;
      end else if (s2_move) begin
        s2_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      e0    <= color_endpoint0;
      e1    <= color_endpoint1;
      csel1 <= color_selectors;
      asel1 <= alpha_selectors;
    end
    if (s1_move) begin
      csel2 <= csel1;
      asel2 <= asel1;
    end
  end

  txbd_color_lane #(.BW(5)) u_lane_low (
    .clk   (clk),
    .en    (s1_move),
    .mode  (e0[txbd_pkg::ModeBit]),
    .a_raw (e0[4:0]),
    .b_raw (e1[4:0]),
    .pal   (pal_low)
  );

  txbd_color_lane #(.BW(6)) u_lane_mid (
    .clk   (clk),
    .en    (s1_move),
    .mode  (e0[txbd_pkg::ModeBit]),
    .a_raw (e0[9:5]),
    .b_raw (e1[10:5]),
    .pal   (pal_mid)
  );

  txbd_color_lane #(.BW(5)) u_lane_high (
    .clk   (clk),
    .en    (s1_move),
    .mode  (e0[txbd_pkg::ModeBit]),
    .a_raw (e0[14:10]),
    .b_raw (e1[15:11]),
    .pal   (pal_high)
  );

  txbd_alpha_lane u_alpha (
    .clk     (clk),
    .load    (accept),
    .advance (s1_move),
    .a0      (alpha_endpoint0),
    .a1      (alpha_endpoint1),
    .pal     (apal)
  );

  txbd_texel_merge u_merge (
    .clk          (clk),
    .rst          (rst),
    .ctl          (ctl),
    .stat         (stat),
    .pal_low_in   (pal_low),
    .pal_mid_in   (pal_mid),
    .pal_high_in  (pal_high),
    .apal_in      (apal),
    .csel_in      (csel2),
    .asel_in      (asel2),
    .texel_valid  (texel_valid),
    .texel_number (texel_number),
    .part_low     (part_low),
    .part_mid     (part_mid),
    .part_high    (part_high),
    .alpha_out    (alpha_out),
    .last_texel   (last_texel)
  );

endmodule

// ===== rtl/txbd_checker.sv =====
module txbd_checker (
  input logic       clk,
  input logic       rst,
  input logic       busy,
  input logic       texel_valid,
  input logic [3:0] texel_number,
  input logic       last_texel
);

  // Last flag marks exactly texel fifteen
  a_last_is_fifteen: assert property (@(posedge clk) disable iff (rst)
    texel_valid |-> (last_texel == (texel_number == 4'd15)))
    else $error("last_texel does not match texel fifteen");

  // A block streams without gaps, in raster order
  a_no_gap: assert property (@(posedge clk) disable iff (rst)
    texel_valid && !last_texel |=>
      texel_valid && (texel_number == 4'($past(texel_number) + 4'd1)))
    else $error("texel beats broke off or skipped");

  // A run of beats opens on texel zero
  a_run_starts_at_zero: assert property (@(posedge clk) disable iff (rst)
    $rose(texel_valid) |-> (texel_number == 4'd0))
    else $error("block did not open on texel zero");

  // Reset leaves the block idle and ready
  a_reset_idle: assert property (@(posedge clk)
    rst |=> !busy && !texel_valid)
    else $error("block not idle after reset");

endmodule

bind atc_texture_block_decoder txbd_checker u_txbd_checker (
  .clk          (clk),
  .rst          (rst),
  .busy         (busy),
  .texel_valid  (texel_valid),
  .texel_number (texel_number),
  .last_texel   (last_texel)
);
